[rtl/core/wsa_pkg.sv]
// ----------------------------------------------------------------------------
// wsa_pkg
// Shared constants, controller states and divider result type for the
// weighted slot apportioner.
// ----------------------------------------------------------------------------
package wsa_pkg;

	localparam int MAX_NODES   = 64;
	localparam int TOTAL_SLOTS = 16384;
	localparam int WEIGHT_BITS = 16;

	localparam int IDX_W   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CNT_W   = $clog2(MAX_NODES + 1);
	localparam int TOTAL_W = WEIGHT_BITS + IDX_W;
	localparam int SHARE_W = $clog2(TOTAL_SLOTS + 1);
	localparam int SUM_W   = SHARE_W + 1;
	localparam int RANGE_W = 14;
	localparam int DVD_W   = WEIGHT_BITS + SHARE_W;
	localparam int STEP_W  = $clog2(DVD_W);

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_FLD_W  = IDX_W + 2 * RANGE_W;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_CHECK,
		ST_RD_W,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_SUM_CHECK,
		ST_LEFT_WAIT,
		ST_EM_RD,
		ST_EM_OUT,
		ST_FAIL
	} state_t;

	typedef struct packed {
		logic               done;
		logic [SHARE_W-1:0] quotient;
		logic [TOTAL_W-1:0] remainder;
	} div_res_t;

endpackage

[rtl/core/wsa_div.sv]
// ----------------------------------------------------------------------------
// wsa_div
// Bit-serial restoring divider: one quotient bit per cycle, DVD_W steps.
// ----------------------------------------------------------------------------
module wsa_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wsa_pkg::DVD_W-1:0]   dividend,
	input  logic [wsa_pkg::TOTAL_W-1:0] divisor,
	output wsa_pkg::div_res_t           res
);

	logic                        busy_q;
	logic                        done_q;
	logic [wsa_pkg::STEP_W-1:0]  step_q;
	logic [wsa_pkg::DVD_W-1:0]   dvd_q;
	logic [wsa_pkg::DVD_W-1:0]   quo_q;
	logic [wsa_pkg::TOTAL_W-1:0] rem_q;
	logic [wsa_pkg::TOTAL_W-1:0] div_q;

	logic [wsa_pkg::TOTAL_W:0]   trial;
	logic                        ge;
	logic [wsa_pkg::TOTAL_W:0]   diff;

	// shift the next dividend bit into the partial remainder
	assign trial = {rem_q, dvd_q[wsa_pkg::DVD_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == wsa_pkg::STEP_W'(wsa_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[wsa_pkg::DVD_W-2:0], 1'b0};
			quo_q <= {quo_q[wsa_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? diff[wsa_pkg::TOTAL_W-1:0] : trial[wsa_pkg::TOTAL_W-1:0];
		end
	end

	assign res.done      = done_q;
	assign res.quotient  = quo_q[wsa_pkg::SHARE_W-1:0];
	assign res.remainder = rem_q;

endmodule

[rtl/core/weighted_slot_apportioner.sv]
// ----------------------------------------------------------------------------
// weighted_slot_apportioner
// Splits a fixed pool of slots into contiguous ranges in proportion to
// per-node weights.
// ----------------------------------------------------------------------------
// Weights stream in one item per cycle; tlast marks the final node of a set
// (weights past MAX_NODES are dropped, but their tlast still closes the set).
// While loading, s_tready is high. After the final weight the block stops
// taking items and runs: each positive-weight node gets
// floor(weight * TOTAL_SLOTS / total weight), raised to at least one, from a
// bit-serial divider (DVD_W = 31 dividend bits). The leftover slots are spread
// one each over the positive nodes in index order, repeating as needed; this
// takes one more division (leftover / positive node count). Then one range
// item per positive node leaves on the master side in index order, waiting
// while the output register is full and the sink not ready (zero-weight nodes
// up to the last positive one emit nothing), with tlast on the final one. A
// zero total weight, or raised shares summing above TOTAL_SLOTS, yields one
// item with tuser (failed) and tlast set and zero range fields. The output
// register lets the next set load while the final item still waits for the
// sink.
// ----------------------------------------------------------------------------
module weighted_slot_apportioner (
	input  logic                           clk,
	input  logic                           arst_n,
	// input side
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [wsa_pkg::IN_DATA_W-1:0]  s_tdata,   // [15:0] weight
	input  logic                           s_tlast,   // last_node
	// output side
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [wsa_pkg::OUT_DATA_W-1:0] m_tdata,   // [5:0] node_index,
	                                                  // [19:6] range_start,
	                                                  // [33:20] range_end, zero pad
	output logic                           m_tuser,   // failed
	output logic                           m_tlast    // last_result
);

	wsa_pkg::state_t state_q, state_d;

	// run state
	logic [wsa_pkg::CNT_W-1:0]   cnt_q;      // nodes stored
	logic [wsa_pkg::TOTAL_W-1:0] total_q;    // weight sum
	logic [wsa_pkg::CNT_W-1:0]   idx_q;      // node being worked on
	logic [wsa_pkg::SUM_W-1:0]   sum_q;      // sum of raised shares
	logic [wsa_pkg::CNT_W-1:0]   npos_q;     // positive-weight nodes
	logic [wsa_pkg::IDX_W-1:0]   lastpos_q;  // last positive-weight node
	logic [wsa_pkg::SHARE_W-1:0] base_q;     // leftover each node gets
	logic [wsa_pkg::CNT_W-1:0]   extra_q;    // nodes still owed one more slot
	logic [wsa_pkg::SHARE_W-1:0] start_q;    // first slot of next range

	// node stores
	logic [wsa_pkg::WEIGHT_BITS-1:0] wmem [wsa_pkg::MAX_NODES];
	logic [wsa_pkg::SHARE_W-1:0]     smem [wsa_pkg::MAX_NODES];
	logic [wsa_pkg::WEIGHT_BITS-1:0] wrd_q;
	logic [wsa_pkg::SHARE_W-1:0]     srd_q;
	logic [wsa_pkg::IDX_W-1:0]       addr;

	// output register
	logic                           m_tvalid_q;
	logic [wsa_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic                           m_tuser_q;
	logic                           m_tlast_q;
	logic                           out_free;

	// control strobes
	logic                           load_acc;
	logic                           div_start;
	logic                           div_left;
	logic                           smem_we;
	logic [wsa_pkg::SHARE_W-1:0]    smem_wdata;
	logic                           share_done;
	logic                           zero_skip;
	logic                           out_load;
	logic                           out_fail;
	logic                           run_done;

	// divider
	logic [wsa_pkg::DVD_W-1:0]      div_dividend;
	logic [wsa_pkg::TOTAL_W-1:0]    div_divisor;
	wsa_pkg::div_res_t              div_res;
	logic [wsa_pkg::SHARE_W-1:0]    share_raised;
	logic [wsa_pkg::SHARE_W-1:0]    range_size;
	logic [wsa_pkg::SHARE_W-1:0]    range_last;
	logic [wsa_pkg::SUM_W-1:0]      left_slots;

	assign addr     = idx_q[wsa_pkg::IDX_W-1:0];
	assign out_free = !m_tvalid_q || m_tready;
	assign load_acc = s_tvalid && s_tready;

	assign share_raised = (div_res.quotient == '0) ? wsa_pkg::SHARE_W'(1) : div_res.quotient;
	assign left_slots   = wsa_pkg::SUM_W'(wsa_pkg::TOTAL_SLOTS) - sum_q;

	// leftover dividend is the undealt slot count, divisor the positive node count
	assign div_dividend = div_left ? wsa_pkg::DVD_W'(left_slots)
	                               : wsa_pkg::DVD_W'(wrd_q) * wsa_pkg::DVD_W'(wsa_pkg::TOTAL_SLOTS);
	assign div_divisor  = div_left ? wsa_pkg::TOTAL_W'(npos_q) : total_q;

	// final size: stored share plus even leftover plus one while extras remain
	assign range_size = srd_q + base_q + wsa_pkg::SHARE_W'(extra_q != '0);
	assign range_last = start_q + range_size - wsa_pkg::SHARE_W'(1);

	wsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.res      (div_res)
	);

	// --- controller ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsa_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		div_start  = 1'b0;
		div_left   = 1'b0;
		smem_we    = 1'b0;
		smem_wdata = '0;
		share_done = 1'b0;
		zero_skip  = 1'b0;
		out_load   = 1'b0;
		out_fail   = 1'b0;
		run_done   = 1'b0;
		unique case (state_q)
			wsa_pkg::ST_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tlast) begin
					state_d = wsa_pkg::ST_CHECK;
				end
			end
			wsa_pkg::ST_CHECK: begin
				state_d = (total_q == '0) ? wsa_pkg::ST_FAIL : wsa_pkg::ST_RD_W;
			end
			wsa_pkg::ST_RD_W: begin
				state_d = (idx_q == cnt_q) ? wsa_pkg::ST_SUM_CHECK : wsa_pkg::ST_DIV_START;
			end
			wsa_pkg::ST_DIV_START: begin
				if (wrd_q == '0) begin
					// zero weight: no share, no division
					smem_we   = 1'b1;
					zero_skip = 1'b1;
					state_d   = wsa_pkg::ST_RD_W;
				end else begin
					div_start = 1'b1;
					state_d   = wsa_pkg::ST_DIV_WAIT;
				end
			end
			wsa_pkg::ST_DIV_WAIT: begin
				if (div_res.done) begin
					smem_we    = 1'b1;
					smem_wdata = share_raised;
					share_done = 1'b1;
					state_d    = wsa_pkg::ST_RD_W;
				end
			end
			wsa_pkg::ST_SUM_CHECK: begin
				if (sum_q > wsa_pkg::SUM_W'(wsa_pkg::TOTAL_SLOTS)) begin
					state_d = wsa_pkg::ST_FAIL;
				end else begin
					div_start = 1'b1;
					div_left  = 1'b1;
					state_d   = wsa_pkg::ST_LEFT_WAIT;
				end
			end
			wsa_pkg::ST_LEFT_WAIT: begin
				if (div_res.done) begin
					state_d = wsa_pkg::ST_EM_RD;
				end
			end
			wsa_pkg::ST_EM_RD: begin
				state_d = wsa_pkg::ST_EM_OUT;
			end
			wsa_pkg::ST_EM_OUT: begin
				if (srd_q == '0) begin
					state_d = wsa_pkg::ST_EM_RD;
				end else if (out_free) begin
					out_load = 1'b1;
					if (addr == lastpos_q) begin
						run_done = 1'b1;
						state_d  = wsa_pkg::ST_LOAD;
					end else begin
						state_d  = wsa_pkg::ST_EM_RD;
					end
				end
			end
			wsa_pkg::ST_FAIL: begin
				if (out_free) begin
					out_load = 1'b1;
					out_fail = 1'b1;
					run_done = 1'b1;
					state_d  = wsa_pkg::ST_LOAD;
				end
			end
			default: begin
				state_d = wsa_pkg::ST_LOAD;
			end
		endcase
	end

	// --- run datapath ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			total_q   <= '0;
			idx_q     <= '0;
			sum_q     <= '0;
			npos_q    <= '0;
			lastpos_q <= '0;
			base_q    <= '0;
			extra_q   <= '0;
			start_q   <= '0;
		end else begin
			if (run_done) begin
				cnt_q   <= '0;
				total_q <= '0;
				idx_q   <= '0;
				sum_q   <= '0;
				npos_q  <= '0;
				start_q <= '0;
			end else begin
				if (load_acc && cnt_q < wsa_pkg::CNT_W'(wsa_pkg::MAX_NODES)) begin
					cnt_q   <= cnt_q + 1'b1;
					total_q <= total_q + wsa_pkg::TOTAL_W'(s_tdata[wsa_pkg::WEIGHT_BITS-1:0]);
				end
				if (zero_skip) begin
					idx_q <= idx_q + 1'b1;
				end
				if (share_done) begin
					idx_q     <= idx_q + 1'b1;
					sum_q     <= sum_q + wsa_pkg::SUM_W'(share_raised);
					npos_q    <= npos_q + 1'b1;
					lastpos_q <= addr;
				end
				if (state_q == wsa_pkg::ST_LEFT_WAIT && div_res.done) begin
					idx_q   <= '0;
					base_q  <= div_res.quotient;
					extra_q <= div_res.remainder[wsa_pkg::CNT_W-1:0];
				end
				if (state_q == wsa_pkg::ST_EM_OUT && srd_q == '0) begin
					idx_q <= idx_q + 1'b1;
				end
				if (out_load && !out_fail) begin
					idx_q   <= idx_q + 1'b1;
					start_q <= start_q + range_size;
					if (extra_q != '0) begin
						extra_q <= extra_q - 1'b1;
					end
				end
			end
		end
	end

	// --- node stores: one write, one registered read each ---
	always_ff @(posedge clk) begin
		if (load_acc && cnt_q < wsa_pkg::CNT_W'(wsa_pkg::MAX_NODES)) begin
			wmem[cnt_q[wsa_pkg::IDX_W-1:0]] <= s_tdata[wsa_pkg::WEIGHT_BITS-1:0];
		end
		wrd_q <= wmem[addr];
	end

	always_ff @(posedge clk) begin
		if (smem_we) begin
			smem[addr] <= smem_wdata;
		end
		srd_q <= smem[addr];
	end

	// --- output register ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tuser_q <= out_fail;
			m_tlast_q <= out_fail || (addr == lastpos_q);
			if (out_fail) begin
				m_tdata_q <= '0;
			end else begin
				m_tdata_q <= {{(wsa_pkg::OUT_DATA_W - wsa_pkg::OUT_FLD_W){1'b0}},
				              range_last[wsa_pkg::RANGE_W-1:0],
				              start_q[wsa_pkg::RANGE_W-1:0],
				              addr};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

endmodule
